[hdl/gmp_pkg.sv]
// gmp_pkg: widths, register indexes, packet constants and the packet record
// shared by the gyro pointer core and its parts. No dependencies.
package gmp_pkg;

   // field and datapath widths
   localparam int RATE_W = 16;
   localparam int SUM_W  = 24;
   localparam int DEV_W  = 25;
   localparam int CNT_W  = 7;
   localparam int DZ_W   = 23;
   localparam int GAIN_W = 16;
   localparam int CODE_W = 16;
   localparam int BYTE_W = 8;
   localparam int PROD_W = DEV_W + GAIN_W;
   localparam int SHIFT  = 24;
   localparam int VAL_W  = PROD_W - SHIFT;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = DZ_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_ZONE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN      = 1'd1;

   // register reset values
   localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 23'd19650;
   localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd1025;

   // packet bytes
   localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] TYPE_X   = 8'h00;
   localparam logic [BYTE_W-1:0] TYPE_Z   = 8'h01;

   // int16 saturation limits on the magnitude
   localparam logic [VAL_W-1:0] POS_LIMIT = 17'd32767;
   localparam logic [VAL_W-1:0] NEG_LIMIT = 17'd32768;

   // one sample's worth of packets waiting to be sent
   typedef struct packed {
      logic              emit_x;
      logic              emit_z;
      logic [CODE_W-1:0] code_x;
      logic [CODE_W-1:0] code_z;
   } pkt_type;

endpackage

[hdl/gmp_scale.sv]
// gmp_scale: dead-zone test, gain scaling and int16 saturation for one axis.
// Depends on gmp_pkg.
module gmp_scale
   import gmp_pkg::*;
(
   input  logic [DEV_W-1:0]  mag,
   input  logic              neg,
   input  logic [DZ_W-1:0]   dead_zone,
   input  logic [GAIN_W-1:0] gain,
   output logic              emit,
   output logic [CODE_W-1:0] code
);

   logic [PROD_W-1:0] prod;
   logic [VAL_W-1:0]  val;
   logic [VAL_W-1:0]  sat;
   logic [VAL_W-1:0]  neg_sat;

   // over the dead zone only when strictly greater
   assign emit = mag > DEV_W'(dead_zone);

   // scale and truncate toward zero on the magnitude
   assign prod = PROD_W'(mag) * PROD_W'(gain);
   assign val  = prod[PROD_W-1:SHIFT];

   // clamp then restore the sign as two's complement
   always_comb begin
      if (neg) begin
         sat = (val > NEG_LIMIT) ? NEG_LIMIT : val;
      end else begin
         sat = (val > POS_LIMIT) ? POS_LIMIT : val;
      end
      neg_sat = VAL_W'(0) - sat;
      code    = neg ? neg_sat[CODE_W-1:0] : sat[CODE_W-1:0];
   end

endmodule

[hdl/gmp_serial.sv]
// gmp_serial: packet register and byte serialiser for the result channel.
// Depends on gmp_pkg.
module gmp_serial
   import gmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  pkt_type           pkt,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_packet_byte,
   output logic              rsp_last_byte
);

   logic        vld_ff, vld_in;
   logic [2:0]  idx_ff, idx_in;
   pkt_type     pkt_ff, pkt_in;
   logic        xfer;
   logic [CODE_W-1:0] code;

   assign rsp_valid     = vld_ff;
   assign xfer          = vld_ff && !rsp_stall;
   // the Z packet is the final one when present
   assign rsp_last_byte = (idx_ff == 3'd7) || (idx_ff == 3'd3 && !pkt_ff.emit_z);
   assign free          = !vld_ff || (xfer && rsp_last_byte);

   // byte select within the current packet
   assign code = idx_ff[2] ? pkt_ff.code_z : pkt_ff.code_x;
   always_comb begin
      case (idx_ff[1:0])
         2'd0:    rsp_packet_byte = HDR_BYTE;
         2'd1:    rsp_packet_byte = idx_ff[2] ? TYPE_Z : TYPE_X;
         2'd2:    rsp_packet_byte = code[7:0];
         default: rsp_packet_byte = code[15:8];
      endcase
   end

   // next state: load a fresh record or step through the bytes
   always_comb begin
      vld_in = vld_ff;
      idx_in = idx_ff;
      pkt_in = pkt_ff;
      if (load) begin
         vld_in = 1'b1;
         idx_in = pkt.emit_x ? 3'd0 : 3'd4;
         pkt_in = pkt;
      end else if (xfer) begin
         if (rsp_last_byte) begin
            vld_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
      pkt_ff <= pkt_in;
   end

endmodule

[hdl/gyro_motion_to_pointer_packets_core.sv]
// gyro_motion_to_pointer_packets_core: bias calibration, dead zone and packet
// output for gyro X/Z samples. Depends on gmp_pkg, gmp_scale and gmp_serial.
//
// Usage: samples (rate_x, rate_z, recalibrate) arrive on the req_ channel and
// packet bytes leave on the rsp_ channel, one byte per transfer, with
// last_byte set on the final byte a sample causes. A sample causes 0, 4 or 8
// bytes: FF, axis type, value low byte, value high byte; X before Z.
// After reset, and from any sample flagged recalibrate, CAL samples are
// summed as the bias and cause no bytes. The csr_ port writes dead_zone
// (index 0) and gain (index 1); reset loads 19650 and 1025 and clears the
// bias sums and the calibration count, so calibration starts afresh.
// A sample that causes bytes passes from the input register through the
// deviation register to the packet register, from which its bytes leave.
// Throughput: one sample per cycle while samples cause no bytes; otherwise
// the single-byte output port sets the pace. One sample is held in each of
// the input and deviation registers while bytes drain. A stall on rsp_
// holds the current byte and, once those registers are full, raises
// req_stall.
module gyro_motion_to_pointer_packets_core
   import gmp_pkg::*;
#(
   parameter int CAL = 100
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [RATE_W-1:0] req_rate_x,
   input  logic signed [RATE_W-1:0] req_rate_z,
   input  logic                    req_recalibrate,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [BYTE_W-1:0]       rsp_packet_byte,
   output logic                    rsp_last_byte,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DAT_W-1:0]    csr_wdata
);

   localparam logic [CNT_W-1:0]         CAL_CNT = CNT_W'(CAL);
   localparam logic signed [DEV_W-1:0]  CAL_S   = DEV_W'(CAL);

   // configuration registers
   logic [DZ_W-1:0]   dead_zone_ff;
   logic [GAIN_W-1:0] gain_ff;

   // input register
   logic                     in_vld_ff, in_vld_in;
   logic signed [RATE_W-1:0] rx_ff, rz_ff;
   logic                     recal_ff;
   logic                     in_adv;

   // calibration state
   logic [SUM_W-1:0] sum_x_ff, sum_x_in, sum_z_ff, sum_z_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // deviation register
   logic             mid_vld_ff, mid_vld_in;
   logic [DEV_W-1:0] mag_x_ff, mag_x_in, mag_z_ff, mag_z_in;
   logic             neg_x_ff, neg_x_in, neg_z_ff, neg_z_in;
   logic             mid_adv;

   // stage working values
   logic [SUM_W-1:0]        base_x, base_z;
   logic [CNT_W-1:0]        base_cnt;
   logic                    calibrating;
   logic signed [DEV_W-1:0] rx_cal, rz_cal, dev_x, dev_z;

   pkt_type pkt;
   logic    pk_free;
   logic    pk_load;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DEAD_ZONE_RST;
         gain_ff      <= GAIN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_DEAD_ZONE: dead_zone_ff <= csr_wdata[DZ_W-1:0];
            REG_GAIN:      gain_ff      <= csr_wdata[GAIN_W-1:0];
            default:       ;
         endcase
      end
   end

   // pipeline flow control
   assign mid_adv   = mid_vld_ff && pk_free;
   assign in_adv    = in_vld_ff && (!mid_vld_ff || mid_adv);
   assign req_stall = in_vld_ff && !in_adv;

   // input register takes a transfer whenever it is empty or moving on
   assign in_vld_in = (req_valid && !req_stall) || (in_vld_ff && !in_adv);
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_valid && !req_stall) begin
         rx_ff    <= req_rate_x;
         rz_ff    <= req_rate_z;
         recal_ff <= req_recalibrate;
      end
   end

   // calibration update and deviation per axis
   always_comb begin
      base_x      = recal_ff ? '0 : sum_x_ff;
      base_z      = recal_ff ? '0 : sum_z_ff;
      base_cnt    = recal_ff ? '0 : cnt_ff;
      calibrating = base_cnt < CAL_CNT;

      rx_cal = DEV_W'(rx_ff) * CAL_S;
      rz_cal = DEV_W'(rz_ff) * CAL_S;
      // X is negated
      dev_x  = DEV_W'($signed(sum_x_ff)) - rx_cal;
      dev_z  = rz_cal - DEV_W'($signed(sum_z_ff));

      sum_x_in   = sum_x_ff;
      sum_z_in   = sum_z_ff;
      cnt_in     = cnt_ff;
      mid_vld_in = mid_vld_ff && !mid_adv;
      if (in_adv) begin
         if (calibrating) begin
            sum_x_in = base_x + SUM_W'(rx_ff);
            sum_z_in = base_z + SUM_W'(rz_ff);
            cnt_in   = base_cnt + CNT_W'(1);
         end else begin
            mid_vld_in = 1'b1;
         end
      end

      neg_x_in = dev_x[DEV_W-1];
      neg_z_in = dev_z[DEV_W-1];
      mag_x_in = neg_x_in ? DEV_W'(-dev_x) : DEV_W'(dev_x);
      mag_z_in = neg_z_in ? DEV_W'(-dev_z) : DEV_W'(dev_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff   <= '0;
         sum_z_ff   <= '0;
         cnt_ff     <= '0;
         mid_vld_ff <= 1'b0;
      end else begin
         sum_x_ff   <= sum_x_in;
         sum_z_ff   <= sum_z_in;
         cnt_ff     <= cnt_in;
         mid_vld_ff <= mid_vld_in;
      end
      if (in_adv) begin
         mag_x_ff <= mag_x_in;
         mag_z_ff <= mag_z_in;
         neg_x_ff <= neg_x_in;
         neg_z_ff <= neg_z_in;
      end
   end

   // scaling per axis
   gmp_scale u_scale_x (
      .mag       (mag_x_ff),
      .neg       (neg_x_ff),
      .dead_zone (dead_zone_ff),
      .gain      (gain_ff),
      .emit      (pkt.emit_x),
      .code      (pkt.code_x)
   );

   gmp_scale u_scale_z (
      .mag       (mag_z_ff),
      .neg       (neg_z_ff),
      .dead_zone (dead_zone_ff),
      .gain      (gain_ff),
      .emit      (pkt.emit_z),
      .code      (pkt.code_z)
   );

   // samples inside the dead zone on both axes are dropped here
   assign pk_load = mid_adv && (pkt.emit_x || pkt.emit_z);

   gmp_serial u_serial (
      .clock           (clock),
      .reset           (reset),
      .load            (pk_load),
      .pkt             (pkt),
      .free            (pk_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

[bench/tb_gyro_motion_to_pointer_packets_core.sv]
// tb_gyro_motion_to_pointer_packets_core: self-checking bench for the gyro pointer core,
// with its own model of bias calibration, dead zone and packet scaling.
// Depends on gmp_pkg and gyro_motion_to_pointer_packets_core.
module tb_gyro_motion_to_pointer_packets_core
   import gmp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAL_SAMPLES   = 100;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 4000;
   localparam int RANDOM_ITEMS  = 94;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_z;
      logic                     recalibrate;
   } gyro_sample_type;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              last;
   } pointer_byte_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [RATE_W-1:0] req_rate_x = '0;
   logic signed [RATE_W-1:0] req_rate_z = '0;
   logic                     req_recalibrate = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [BYTE_W-1:0]        rsp_packet_byte;
   logic                     rsp_last_byte;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = REG_DEAD_ZONE;
   logic [CSR_DAT_W-1:0]     csr_wdata = '0;

   // samples waiting to be driven, and packet bytes still owed by the core
   gyro_sample_type   sample_queue[$];
   pointer_byte_type  pending_bytes[$];
   logic [BYTE_W-1:0] sample_bytes[$];

   // model state and register copies
   logic [SUM_W-1:0]  bias_x_q;
   logic [SUM_W-1:0]  bias_z_q;
   int                cal_taken;
   logic [DZ_W-1:0]   dead_zone_q;
   logic [GAIN_W-1:0] gain_q;

   int fail_count   = 0;
   int idle_cycles  = 0;
   int gap_left     = 0;
   int stall_left   = 0;
   int stretch_left = 0;
   bit quiet_stretch = 1'b0;

   gyro_motion_to_pointer_packets_core #(
      .CAL(CAL_SAMPLES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rate_x      (req_rate_x),
      .req_rate_z      (req_rate_z),
      .req_recalibrate (req_recalibrate),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_last_byte   (rsp_last_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // idle and stall lengths: mostly none or short, now and then long
   function automatic int idle_length();
      int r;
      if (quiet_stretch)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one axis: dead zone, fixed-point scaling towards zero, int16 clamp
   function automatic void add_axis(longint dev, logic [BYTE_W-1:0] kind);
      longint            mag;
      longint            level;
      logic [CODE_W-1:0] code;
      mag = (dev < 0) ? -dev : dev;
      if (mag <= longint'(dead_zone_q))
         return;
      level = (mag * longint'(gain_q)) >>> SHIFT;
      if (dev < 0) begin
         if (level > 32768)
            level = 32768;
         code = CODE_W'(-level);
      end else begin
         if (level > 32767)
            level = 32767;
         code = CODE_W'(level);
      end
      sample_bytes.push_back(HDR_BYTE);
      sample_bytes.push_back(kind);
      sample_bytes.push_back(code[7:0]);
      sample_bytes.push_back(code[15:8]);
   endfunction

   // bias accumulation while calibrating, packet bytes afterwards
   function automatic void predict_sample(gyro_sample_type s);
      longint dev_x;
      longint dev_z;
      if (s.recalibrate) begin
         bias_x_q  = '0;
         bias_z_q  = '0;
         cal_taken = 0;
      end
      if (cal_taken < CAL_SAMPLES) begin
         bias_x_q = bias_x_q + {{(SUM_W-RATE_W){s.rate_x[RATE_W-1]}}, s.rate_x};
         bias_z_q = bias_z_q + {{(SUM_W-RATE_W){s.rate_z[RATE_W-1]}}, s.rate_z};
         cal_taken++;
         return;
      end
      // x axis is negated
      dev_x = longint'($signed(bias_x_q)) - longint'($signed(s.rate_x)) * CAL_SAMPLES;
      dev_z = longint'($signed(s.rate_z)) * CAL_SAMPLES - longint'($signed(bias_z_q));
      sample_bytes.delete();
      add_axis(dev_x, TYPE_X);
      add_axis(dev_z, TYPE_Z);
      foreach (sample_bytes[i])
         pending_bytes.push_back('{value: sample_bytes[i],
                                   last: (i == sample_bytes.size() - 1)});
   endfunction

   // alternate stretches with and without idling
   always @(posedge clock) begin
      if (stretch_left == 0) begin
         quiet_stretch <= !quiet_stretch;
         stretch_left = $urandom_range(60, 300);
      end else
         stretch_left--;
   end

   // sample driver: a transfer goes to the model, then the next sample or a gap
   always @(posedge clock) begin : drive_samples
      gyro_sample_type next_sample;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_sample('{rate_x: req_rate_x, rate_z: req_rate_z,
                             recalibrate: req_recalibrate});
            gap_left = idle_length();
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               next_sample = sample_queue.pop_front();
               req_valid       <= 1'b1;
               req_rate_x      <= next_sample.rate_x;
               req_rate_z      <= next_sample.rate_z;
               req_recalibrate <= next_sample.recalibrate;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // byte monitor: compare each transfer with the oldest owed byte, random stalls
   always @(posedge clock) begin : check_bytes
      pointer_byte_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_bytes.size() == 0) begin
               $error("packet_byte: nothing expected, got %02h", rsp_packet_byte);
               fail_count++;
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_packet_byte !== want.value) begin
                  $error("packet_byte: expected %02h, got %02h", want.value, rsp_packet_byte);
                  fail_count++;
               end
               if (rsp_last_byte !== want.last) begin
                  $error("last_byte: expected %0b, got %0b", want.last, rsp_last_byte);
                  fail_count++;
               end
            end
         end
         if (stall_left == 0)
            stall_left = idle_length();
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no transfer and no register write
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("gyro_motion_to_pointer_packets_core test failed");
      $finish;
   end

   function automatic int random_rate();
      return int'($signed(16'($urandom)));
   endfunction

   function automatic int near_value(int centre, int spread);
      int v;
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v;
   endfunction

   // operating samples: mostly close to the bias, some wide, a few at full scale
   function automatic int pick_rate(int centre);
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return near_value(centre, 300);
      if (r < 70)
         return near_value(centre, 30);
      if (r < 92)
         return random_rate();
      case ($urandom_range(0, 3))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   function automatic int unsigned pick_dead_zone();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return $urandom_range(0, 2000);
         2: return $urandom_range(0, 40000);
         3: return $urandom_range(0, 6553600);
         default: return DEAD_ZONE_RST;
      endcase
   endfunction

   function automatic int unsigned pick_gain();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 65535;
         2: return $urandom_range(0, 65535);
         3: return $urandom_range(500, 5000);
         default: return GAIN_RST;
      endcase
   endfunction

   task automatic put_sample(int rx, int rz, bit recal);
      sample_queue.push_back('{rate_x: RATE_W'(rx), rate_z: RATE_W'(rz), recalibrate: recal});
   endtask

   // full calibration run, the first sample flagged
   task automatic put_calibration(int cx, int cz, int noise);
      put_sample(near_value(cx, noise), near_value(cz, noise), 1'b1);
      repeat (CAL_SAMPLES - 1)
         put_sample(near_value(cx, noise), near_value(cz, noise), 1'b0);
   endtask

   // all samples taken, all bytes seen, then room for a silent sample in flight
   task automatic wait_until_quiet();
      do
         @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || pending_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, int unsigned data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DAT_W'(data);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_DEAD_ZONE)
         dead_zone_q = DZ_W'(data);
      else
         gain_q = GAIN_W'(data);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int random_done;
      int seg_ops;
      int cx;
      int cz;
      dead_zone_q = DEAD_ZONE_RST;
      gain_q      = GAIN_RST;
      bias_x_q    = '0;
      bias_z_q    = '0;
      cal_taken   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // calibration after reset, dropped part-way by a recalibrate to a zero bias
      repeat (20) put_sample(random_rate(), random_rate(), 1'b0);
      put_calibration(0, 0, 0);
      // either side of the reset dead zone, then full scale
      put_sample(196, -196, 1'b0);
      put_sample(197, -197, 1'b0);
      put_sample(-32768, 32767, 1'b0);
      put_sample(32767, -32768, 1'b0);
      put_sample(0, 0, 1'b0);
      put_sample(-1, 1, 1'b0);
      wait_until_quiet();

      // no dead zone, full gain: tiny deviations still send packets
      write_register(REG_DEAD_ZONE, 0);
      write_register(REG_GAIN, 65535);
      put_sample(1, 0, 1'b0);
      put_sample(0, -1, 1'b0);
      put_sample(0, 0, 1'b0);
      // recalibrate after calibration, to the largest bias, then largest deviation
      put_calibration(32767, -32768, 0);
      put_sample(-32768, 32767, 1'b0);
      put_sample(32767, -32768, 1'b0);
      wait_until_quiet();

      // zero gain just under the largest deviation
      write_register(REG_DEAD_ZONE, 6553499);
      write_register(REG_GAIN, 0);
      put_sample(-32768, 32767, 1'b0);
      put_sample(-32767, 32766, 1'b0);
      wait_until_quiet();

      // widest dead zone swallows everything
      write_register(REG_DEAD_ZONE, 6553600);
      write_register(REG_GAIN, GAIN_RST);
      put_sample(-32768, 32767, 1'b0);
      wait_until_quiet();

      // deviation equal to the dead zone, then one step past it
      write_register(REG_DEAD_ZONE, 19600);
      put_sample(32571, -32572, 1'b0);
      put_sample(32570, -32571, 1'b0);
      wait_until_quiet();

      // random segments around the full-scale bias, each with its own register setting
      random_done = 0;
      cx = 32767;
      cz = -32768;
      while (random_done < RANDOM_ITEMS) begin
         write_register(REG_DEAD_ZONE, pick_dead_zone());
         write_register(REG_GAIN, pick_gain());
         seg_ops = $urandom_range(20, 40);
         if (seg_ops > RANDOM_ITEMS - random_done)
            seg_ops = RANDOM_ITEMS - random_done;
         repeat (seg_ops)
            put_sample(pick_rate(cx), pick_rate(cz), ($urandom_range(0, 49) == 0));
         random_done += seg_ops;
         wait_until_quiet();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("gyro_motion_to_pointer_packets_core test passed");
      else
         $display("gyro_motion_to_pointer_packets_core test failed");
      $finish;
   end

endmodule
